@@ sv/mmsp_pkg.sv @@
// Shared types, codes and constants of the music macro string parser.
// No dependencies; every other file but mmsp_if.sv takes its names from here by scope.
package mmsp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_OARG = 4'd1,
    PH_MARG = 4'd2,
    PH_LNUM = 4'd3,
    PH_TNUM = 4'd4,
    PH_NNUM = 4'd5,
    PH_NACC = 4'd6,
    PH_NLEN = 4'd7,
    PH_NDOT = 4'd8,
    PH_ERR  = 4'd9
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_NOTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // articulation modes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_LEGATO   = 2'd1;
  localparam logic [1:0] MODE_STACCATO = 2'd2;

  // register map (byte addresses)
  localparam int         CFG_AW          = 4;
  localparam logic [3:0] ADDR_START_TEMPO  = 4'h0;
  localparam logic [3:0] ADDR_START_LENGTH = 4'h4;
  localparam logic [3:0] ADDR_START_OCTAVE = 4'h8;

  // register reset values
  localparam logic [7:0] RST_TEMPO  = 8'd120;
  localparam logic [6:0] RST_LENGTH = 7'd4;
  localparam logic [2:0] RST_OCTAVE = 3'd4;

  // limits
  localparam logic [6:0] NOTE_MAX   = 7'd84;
  localparam logic [6:0] LEN_MAX    = 7'd64;
  localparam logic [7:0] TEMPO_MIN  = 8'd32;
  localparam logic [2:0] OCT_MAX    = 3'd6;
  localparam logic [9:0] ACC_MAX    = 10'd999;
  localparam logic [3:0] DOTS_MAX   = 4'd15;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // start values as held in the registers
  typedef struct packed {
    logic [7:0] tempo;
    logic [6:0] length;
    logic [2:0] octave;
  } start_cfg_t;

  // one result without its last flag
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note_number;
    logic [6:0] length_divisor;
    logic [3:0] dot_count;
    logic [7:0] tempo_now;
    logic [1:0] articulation;
  } result_t;

  // results of one character: a first result and perhaps a bare second one
  typedef struct packed {
    result_t    first;
    logic       two;
    logic [1:0] kind2;
  } q_entry_t;

  // semitones above C for letters A..G
  function automatic logic [3:0] semis_from_c(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

@@ sv/mmsp_if.sv @@
// Channel interfaces of the music macro string parser: character in, result out.
// Depends on nothing but the widths of the work fields.
interface mmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface mmsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] note_number;
  logic [6:0] length_divisor;
  logic [3:0] dot_count;
  logic [7:0] tempo_now;
  logic [1:0] articulation;
  logic       last;

  modport source (output valid, output kind, output note_number, output length_divisor,
                  output dot_count, output tempo_now, output articulation, output last,
                  input ready);
  modport sink   (input valid, input kind, input note_number, input length_divisor,
                  input dot_count, input tempo_now, input articulation, input last,
                  output ready);
endinterface

@@ sv/mmsp_cfg.sv @@
// APB-style register block holding the start tempo, length and octave.
// Depends on mmsp_pkg for the register map and reset values.
module mmsp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmsp_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output mmsp_pkg::start_cfg_t          start_cfg
);

  logic [7:0] tempo_r;
  logic [6:0] length_r;
  logic [2:0] octave_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r  <= mmsp_pkg::RST_TEMPO;
      length_r <= mmsp_pkg::RST_LENGTH;
      octave_r <= mmsp_pkg::RST_OCTAVE;
    end else if (wr_en) begin
      case (paddr)
        mmsp_pkg::ADDR_START_TEMPO:  tempo_r  <= pwdata[7:0];
        mmsp_pkg::ADDR_START_LENGTH: length_r <= pwdata[6:0];
        mmsp_pkg::ADDR_START_OCTAVE: octave_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr)
      mmsp_pkg::ADDR_START_TEMPO:  prdata = {24'd0, tempo_r};
      mmsp_pkg::ADDR_START_LENGTH: prdata = {25'd0, length_r};
      mmsp_pkg::ADDR_START_OCTAVE: prdata = {29'd0, octave_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign start_cfg.tempo  = tempo_r;
  assign start_cfg.length = length_r;
  assign start_cfg.octave = octave_r;

endmodule

@@ sv/mmsp_parser.sv @@
// Parser state and the per-character step: one character in, up to two results out.
// Depends on mmsp_pkg for phases, codes, limits and the result entry type.
module mmsp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ch_vld,
  input  logic [7:0]            ch,
  input  mmsp_pkg::start_cfg_t  start_cfg,
  output logic                  push,
  output mmsp_pkg::q_entry_t    push_entry
);

  mmsp_pkg::phase_t phase_r, phase_nxt;
  logic [9:0] acc_r, acc_nxt;
  logic [6:0] pnote_r, pnote_nxt;
  logic [6:0] plen_r, plen_nxt;
  logic [3:0] pdots_r, pdots_nxt;
  logic [2:0] octave_r, octave_nxt;
  logic [6:0] length_r, length_nxt;
  logic [7:0] tempo_r, tempo_nxt;
  logic [1:0] mode_r, mode_nxt;

  // clamped start values
  logic [2:0] st_octave;
  logic [6:0] st_length;
  logic [7:0] st_tempo;

  // character classes
  logic [7:0] u;
  logic       is_nul, is_ws, is_dig, is_oct_dig, is_plus, is_minus, is_mletter, is_dot;
  logic       is_known;
  logic [3:0] dval;
  logic [13:0] acc_wide;
  logic [9:0] acc_ext;

  // step decisions
  logic       ext_done, err_close, note_close, cmd_path;
  logic       dot_hit, emit_note, run_cmd, cmd_bad, emit_err, emit_end;
  logic [6:0] eff_note, eff_len;
  logic [6:0] letter_note;

  assign st_octave = (start_cfg.octave > mmsp_pkg::OCT_MAX) ? mmsp_pkg::OCT_MAX
                                                            : start_cfg.octave;
  assign st_length = (start_cfg.length == 7'd0) ? 7'd1 :
                     (start_cfg.length > mmsp_pkg::LEN_MAX) ? mmsp_pkg::LEN_MAX
                                                            : start_cfg.length;
  assign st_tempo  = (start_cfg.tempo < mmsp_pkg::TEMPO_MIN) ? mmsp_pkg::TEMPO_MIN
                                                             : start_cfg.tempo;

  // classify the character
  assign u          = (ch >= mmsp_pkg::CH_LA && ch <= mmsp_pkg::CH_LZ)
                      ? ch - mmsp_pkg::CASE_GAP : ch;
  assign is_nul     = (ch == mmsp_pkg::CH_NUL);
  assign is_ws      = (ch == mmsp_pkg::CH_SPACE) ||
                      (ch >= mmsp_pkg::CH_TAB && ch <= mmsp_pkg::CH_CR);
  assign is_dig     = (ch >= mmsp_pkg::CH_0 && ch <= mmsp_pkg::CH_9);
  assign is_oct_dig = (ch >= mmsp_pkg::CH_0 && ch <= mmsp_pkg::CH_6);
  assign is_plus    = (ch == mmsp_pkg::CH_PLUS) || (ch == mmsp_pkg::CH_HASH);
  assign is_minus   = (ch == mmsp_pkg::CH_MINUS);
  assign is_dot     = (ch == mmsp_pkg::CH_DOT);
  assign is_mletter = (u == mmsp_pkg::CH_L) || (u == mmsp_pkg::CH_N) ||
                      (u == mmsp_pkg::CH_S) || (u == mmsp_pkg::CH_B) ||
                      (u == mmsp_pkg::CH_F);
  assign is_known   = (u == mmsp_pkg::CH_O) || (u == mmsp_pkg::CH_LT) ||
                      (u == mmsp_pkg::CH_GT) || (u == mmsp_pkg::CH_M) ||
                      (u == mmsp_pkg::CH_L) || (u == mmsp_pkg::CH_T) ||
                      (u >= mmsp_pkg::CH_A && u <= mmsp_pkg::CH_G) ||
                      (u == mmsp_pkg::CH_N) || (u == mmsp_pkg::CH_P);
  assign dval       = ch[3:0];

  // accumulator times ten plus digit, saturating
  assign acc_wide = {1'b0, acc_r, 3'd0} + {3'd0, acc_r, 1'b0} + {10'd0, dval};
  assign acc_ext  = (acc_wide > {4'd0, mmsp_pkg::ACC_MAX}) ? mmsp_pkg::ACC_MAX
                                                           : acc_wide[9:0];

  // note number of a letter in the current octave
  assign letter_note = 7'd1 + {1'b0, octave_r, 3'd0} + {2'd0, octave_r, 2'd0} +
                       {3'd0, mmsp_pkg::semis_from_c(u[2:0] - mmsp_pkg::CH_A[2:0])};

  // how the command in progress reacts to this character
  always_comb begin
    ext_done   = 1'b0;
    err_close  = 1'b0;
    note_close = 1'b0;
    cmd_path   = 1'b0;
    case (phase_r)
      mmsp_pkg::PH_IDLE: cmd_path = 1'b1;
      mmsp_pkg::PH_OARG: begin
        if (is_oct_dig) ext_done = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_MARG: begin
        if (is_mletter) ext_done = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_LNUM: begin
        if (is_dig) ext_done = 1'b1;
        else if (acc_r >= 10'd1 && acc_r <= {3'd0, mmsp_pkg::LEN_MAX}) cmd_path = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_TNUM: begin
        if (is_dig) ext_done = 1'b1;
        else if (acc_r >= {2'd0, mmsp_pkg::TEMPO_MIN} && acc_r <= 10'd255) cmd_path = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_NNUM: begin
        if (is_dig) ext_done = 1'b1;
        else if (acc_r <= {3'd0, mmsp_pkg::NOTE_MAX}) note_close = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_NLEN: begin
        if (is_dig) ext_done = 1'b1;
        else if (acc_r <= {3'd0, mmsp_pkg::LEN_MAX}) note_close = 1'b1;
        else err_close = 1'b1;
      end
      mmsp_pkg::PH_NACC: begin
        if (is_plus || is_minus || is_dig) ext_done = 1'b1;
        else note_close = 1'b1;
      end
      mmsp_pkg::PH_NDOT: note_close = 1'b1;
      default: ext_done = 1'b1;
    endcase
  end

  assign eff_note  = (phase_r == mmsp_pkg::PH_NNUM) ? acc_r[6:0] : pnote_r;
  assign eff_len   = (phase_r == mmsp_pkg::PH_NLEN && acc_r != 10'd0) ? acc_r[6:0] : plen_r;
  assign dot_hit   = note_close & is_dot;
  assign emit_note = note_close & ~is_dot;
  assign run_cmd   = cmd_path | emit_note;
  assign cmd_bad   = run_cmd & ~is_nul & ~is_ws & ~is_known;
  assign emit_err  = err_close | cmd_bad;
  assign emit_end  = is_nul & (run_cmd | err_close | (phase_r == mmsp_pkg::PH_ERR));

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    pnote_nxt  = pnote_r;
    plen_nxt   = plen_r;
    pdots_nxt  = pdots_r;
    octave_nxt = octave_r;
    length_nxt = length_r;
    tempo_nxt  = tempo_r;
    mode_nxt   = mode_r;
    if (ch_vld) begin
      if (emit_end) begin
        // end of string resets the parser and restores octave, length and tempo from the registers
        phase_nxt  = mmsp_pkg::PH_IDLE;
        acc_nxt    = 10'd0;
        pnote_nxt  = 7'd0;
        plen_nxt   = 7'd0;
        pdots_nxt  = 4'd0;
        octave_nxt = st_octave;
        length_nxt = st_length;
        tempo_nxt  = st_tempo;
        mode_nxt   = mmsp_pkg::MODE_NORMAL;
      end else begin
        // extend or close the command in progress
        case (phase_r)
          mmsp_pkg::PH_OARG: begin
            if (ext_done) begin
              octave_nxt = ch[2:0];
              phase_nxt  = mmsp_pkg::PH_IDLE;
            end
          end
          mmsp_pkg::PH_MARG: begin
            if (ext_done) begin
              if (u == mmsp_pkg::CH_L) mode_nxt = mmsp_pkg::MODE_LEGATO;
              else if (u == mmsp_pkg::CH_N) mode_nxt = mmsp_pkg::MODE_NORMAL;
              else if (u == mmsp_pkg::CH_S) mode_nxt = mmsp_pkg::MODE_STACCATO;
              phase_nxt = mmsp_pkg::PH_IDLE;
            end
          end
          mmsp_pkg::PH_LNUM: begin
            if (ext_done) acc_nxt = acc_ext;
            else if (cmd_path) length_nxt = acc_r[6:0];
          end
          mmsp_pkg::PH_TNUM: begin
            if (ext_done) acc_nxt = acc_ext;
            else if (cmd_path) tempo_nxt = acc_r[7:0];
          end
          mmsp_pkg::PH_NNUM, mmsp_pkg::PH_NLEN: begin
            if (ext_done) acc_nxt = acc_ext;
          end
          mmsp_pkg::PH_NACC: begin
            if (is_plus) begin
              if (pnote_r < mmsp_pkg::NOTE_MAX) pnote_nxt = pnote_r + 7'd1;
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_NLEN;
            end else if (is_minus) begin
              if (pnote_r > 7'd1) pnote_nxt = pnote_r - 7'd1;
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_NLEN;
            end else if (is_dig) begin
              acc_nxt   = {6'd0, dval};
              phase_nxt = mmsp_pkg::PH_NLEN;
            end
          end
          default: ;
        endcase

        // dots or the finished note
        if (note_close) begin
          pnote_nxt = eff_note;
          plen_nxt  = eff_len;
          if (dot_hit) begin
            if (pdots_r < mmsp_pkg::DOTS_MAX) pdots_nxt = pdots_r + 4'd1;
            phase_nxt = mmsp_pkg::PH_NDOT;
          end
        end

        // error halts, otherwise a new command starts (with a length just set by L)
        if (emit_err) begin
          phase_nxt = mmsp_pkg::PH_ERR;
        end else if (run_cmd) begin
          phase_nxt = mmsp_pkg::PH_IDLE;
          if (!is_ws) begin
            if (u == mmsp_pkg::CH_O) begin
              phase_nxt = mmsp_pkg::PH_OARG;
            end else if (u == mmsp_pkg::CH_LT) begin
              if (octave_r != 3'd0) octave_nxt = octave_r - 3'd1;
            end else if (u == mmsp_pkg::CH_GT) begin
              if (octave_r < mmsp_pkg::OCT_MAX) octave_nxt = octave_r + 3'd1;
            end else if (u == mmsp_pkg::CH_M) begin
              phase_nxt = mmsp_pkg::PH_MARG;
            end else if (u == mmsp_pkg::CH_L) begin
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_LNUM;
            end else if (u == mmsp_pkg::CH_T) begin
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_TNUM;
            end else if (u >= mmsp_pkg::CH_A && u <= mmsp_pkg::CH_G) begin
              pnote_nxt = letter_note;
              plen_nxt  = length_nxt;
              pdots_nxt = 4'd0;
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_NACC;
            end else if (u == mmsp_pkg::CH_N) begin
              plen_nxt  = length_nxt;
              pdots_nxt = 4'd0;
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_NNUM;
            end else if (u == mmsp_pkg::CH_P) begin
              pnote_nxt = 7'd0;
              plen_nxt  = length_nxt;
              pdots_nxt = 4'd0;
              acc_nxt   = 10'd0;
              phase_nxt = mmsp_pkg::PH_NLEN;
            end
          end
        end
      end
    end
  end

  // results of this character
  always_comb begin
    push_entry = '0;
    if (emit_note) begin
      push_entry.first.kind           = mmsp_pkg::KIND_NOTE;
      push_entry.first.note_number    = eff_note;
      push_entry.first.length_divisor = eff_len;
      push_entry.first.dot_count      = pdots_r;
      push_entry.first.tempo_now      = tempo_r;
      push_entry.first.articulation   = mode_r;
    end else if (emit_err) begin
      push_entry.first.kind = mmsp_pkg::KIND_ERR;
    end else begin
      push_entry.first.kind = mmsp_pkg::KIND_END;
    end
    push_entry.two   = (emit_note & (cmd_bad | emit_end)) | (err_close & is_nul);
    push_entry.kind2 = (emit_note & cmd_bad) ? mmsp_pkg::KIND_ERR : mmsp_pkg::KIND_END;
  end

  assign push = ch_vld & (emit_note | emit_err | emit_end);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mmsp_pkg::PH_IDLE;
      acc_r    <= 10'd0;
      pnote_r  <= 7'd0;
      plen_r   <= 7'd0;
      pdots_r  <= 4'd0;
      octave_r <= mmsp_pkg::RST_OCTAVE;
      length_r <= mmsp_pkg::RST_LENGTH;
      tempo_r  <= mmsp_pkg::RST_TEMPO;
      mode_r   <= mmsp_pkg::MODE_NORMAL;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      pnote_r  <= pnote_nxt;
      plen_r   <= plen_nxt;
      pdots_r  <= pdots_nxt;
      octave_r <= octave_nxt;
      length_r <= length_nxt;
      tempo_r  <= tempo_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // end of string leaves a clean idle parser
  a_end_restores: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_vld && emit_end) |=> (phase_r == mmsp_pkg::PH_IDLE && acc_r == 10'd0))
    else $error("parser not restored after end of string");

  // a second result only ever follows a note or an error
  a_two_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.two) |-> (emit_note || err_close))
    else $error("second result without a leading note or error");

  // octave stays in range
  a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
    octave_r <= mmsp_pkg::OCT_MAX)
    else $error("octave out of range");

endmodule

@@ sv/mmsp_res_queue.sv @@
// Result queue: holds per-character result entries and hands out one result per beat.
// Depends on mmsp_pkg for the entry type and queue depth, and on mmsp_out_if.
module mmsp_res_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  mmsp_pkg::q_entry_t        push_entry,
  output logic [mmsp_pkg::Q_CW-1:0] level,
  mmsp_out_if.source                out_bus
);

  mmsp_pkg::q_entry_t          entries [mmsp_pkg::Q_DEPTH];
  logic [mmsp_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [mmsp_pkg::Q_CW-1:0]   count_r, count_nxt;
  logic                        half_r;
  logic                        beat, pop;
  mmsp_pkg::q_entry_t          head;

  assign head  = entries[rd_ptr_r];
  assign level = count_r;

  // present the head entry, its second result when half_r is set
  assign out_bus.valid          = (count_r != '0);
  assign out_bus.kind           = half_r ? head.kind2 : head.first.kind;
  assign out_bus.note_number    = half_r ? 7'd0 : head.first.note_number;
  assign out_bus.length_divisor = half_r ? 7'd0 : head.first.length_divisor;
  assign out_bus.dot_count      = half_r ? 4'd0 : head.first.dot_count;
  assign out_bus.tempo_now      = half_r ? 8'd0 : head.first.tempo_now;
  assign out_bus.articulation   = half_r ? 2'd0 : head.first.articulation;
  assign out_bus.last           = half_r | ~head.two;

  assign beat = out_bus.valid & out_bus.ready;
  assign pop  = beat & (half_r | ~head.two);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + {{(mmsp_pkg::Q_CW-1){1'b0}}, 1'b1};
    else if (!push && pop) count_nxt = count_r - {{(mmsp_pkg::Q_CW-1){1'b0}}, 1'b1};
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr_r] <= push_entry;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + {{(mmsp_pkg::Q_AW-1){1'b0}}, 1'b1};
      if (pop) rd_ptr_r <= rd_ptr_r + {{(mmsp_pkg::Q_AW-1){1'b0}}, 1'b1};
      if (beat) half_r <= ~pop;
      count_r <= count_nxt;
    end
  end

  // never written when full, unless an entry leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < mmsp_pkg::Q_DEPTH[mmsp_pkg::Q_CW-1:0]) || pop)
    else $error("result queue overflow");

  // second half only on a two-result entry
  a_half_two: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (out_bus.valid && head.two))
    else $error("second result shown for a single-result entry");

  // a beat that is not last leaves its partner waiting
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !out_bus.last) |=> (out_bus.valid && half_r))
    else $error("second result lost");

endmodule

@@ sv/music_macro_string_parser_core.sv @@
// Music macro string parser: character input register, parser step, result queue.
// Depends on mmsp_pkg, mmsp_in_if / mmsp_out_if, mmsp_cfg, mmsp_parser, mmsp_res_queue.
//
// One character per beat goes in; each character yields zero, one or two results
// (a note event, a parse error, an end of string) with last set on the final one.
// A character is registered on accept and parsed in the next cycle, where its
// results enter a four-entry queue that drives the result port directly; a
// character can be taken every cycle while results drain at one a cycle, so the
// input stalls only when two-result characters or a slow sink fill the queue.
// Results pass the input register and a queue entry before they appear. The start
// registers take effect after reset and at every end of string.
module music_macro_string_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mmsp_in_if.sink                       in_bus,
  mmsp_out_if.source                    out_bus,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmsp_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  mmsp_pkg::start_cfg_t          start_cfg;
  logic                          ch_vld_r;
  logic [7:0]                    ch_r;
  logic                          push;
  mmsp_pkg::q_entry_t            push_entry;
  logic [mmsp_pkg::Q_CW-1:0]     level;
  logic [mmsp_pkg::Q_CW:0]       demand;

  // room for the character in flight and one more
  assign demand       = {1'b0, level} + {{mmsp_pkg::Q_CW{1'b0}}, ch_vld_r};
  assign in_bus.ready = (demand < mmsp_pkg::Q_DEPTH[mmsp_pkg::Q_CW:0]);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 1'b0;
    end else begin
      ch_vld_r <= in_bus.valid & in_bus.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) ch_r <= in_bus.ch;
  end

  mmsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start_cfg (start_cfg)
  );

  mmsp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .ch_vld     (ch_vld_r),
    .ch         (ch_r),
    .start_cfg  (start_cfg),
    .push       (push),
    .push_entry (push_entry)
  );

  mmsp_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .level      (level),
    .out_bus    (out_bus)
  );

  // a character in flight always finds queue space
  a_room_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ch_vld_r |-> (level < mmsp_pkg::Q_DEPTH[mmsp_pkg::Q_CW-1:0]))
    else $error("character parsed without queue space");

  // results only come from a parsed character
  a_push_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ch_vld_r)
    else $error("result pushed with no character");

endmodule
